@@ src/rot90_pkg.sv @@
package rot90_pkg;

   // frame geometry
   localparam int MAX_SIDE       = 64;
   localparam int SIDE_BITS      = $clog2(MAX_SIDE);
   localparam int CFG_BITS       = 7;
   localparam int PIXEL_BITS     = 32;

   // two banks side by side, bank select is the top address bit
   localparam int ADDR_BITS      = 2 * SIDE_BITS + 1;
   localparam int STORE_WORDS    = 2 ** ADDR_BITS;

   // result queue
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;
   localparam int FIFO_LIMIT     = 3;

   typedef logic [SIDE_BITS-1:0]  pos_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      pixel_type pixel;
      logic      frame_end;
   } rsp_item_type;

   // side register value to (side in use - 1), zero means one, large means max
   function automatic pos_type side_to_last(input logic [CFG_BITS-1:0] value);
      pos_type last;
      if (value == '0) begin
         last = '0;
      end else if (int'(value) > MAX_SIDE) begin
         last = pos_type'(MAX_SIDE - 1);
      end else begin
         last = pos_type'(value - CFG_BITS'(1));
      end
      return last;
   endfunction

endpackage

@@ src/matrix_rotate_90_clockwise_unit.sv @@
// streaming 90 degree clockwise rotation of square frames of frame_side by frame_side
// elements (1 to 64; 0 acts as 1, larger values as 64). elements enter in row-major order,
// one item per clock while req_stall is low, and go into one of two frame banks while the
// previous frame is read out rotated in the same cycle: every accepted item after the first
// full frame yields one rotated element of the previous frame, with rsp_frame_end on its
// last element. nothing comes out during the first frame after reset or after a frame_side
// write, and the last frame is flushed by sending one more frame, even of dummy elements.
// throughput is one item per cycle while req_stall is low, set by the frame store's single
// write port and single read port, both used once per item; the memory read is registered
// at the accepting edge and the result is then written into the result queue, from which it
// is valid on rsp_. req_stall rises only while the result queue is backed up by rsp_stall.
// writing frame_side restarts the stream and drops any partial or pending frame; write it
// only while the block is idle. no clearing pass after reset.
module matrix_rotate_90_clockwise_unit (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [rot90_pkg::PIXEL_BITS-1:0] req_pixel_in,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [rot90_pkg::PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                              rsp_frame_end,
   // frame side register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rot90_pkg::CFG_BITS-1:0]    csr_frame_side
);
   import rot90_pkg::*;

   // stream position and bank control
   pos_type  row_ff, row_in;
   pos_type  col_ff, col_in;
   pos_type  last_ff, last_in;        // side in use minus one
   logic     bank_ff, bank_in;        // bank being written
   logic     prev_ready_ff, prev_ready_in;

   // read stage: memory read in flight
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_end_ff;

   logic     accept;
   logic     csr_write;
   pos_type  row_use, col_use;
   logic     col_wrap, row_wrap;
   logic     rd_en;
   addr_type wr_addr, rd_addr;
   pixel_type rd_data;

   rsp_item_type              push_item;
   rsp_item_type              head_item;
   logic [FIFO_CNT_BITS-1:0]  fifo_count;
   logic                      pop;

   // stall from registers only: room for the read in flight plus one more
   assign req_stall = ({{(FIFO_CNT_BITS-1){1'b0}}, s1_valid_ff} + fifo_count)
                      >= FIFO_CNT_BITS'(FIFO_LIMIT);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      // out-of-frame positions restart at the origin
      if (row_ff > last_ff || col_ff > last_ff) begin
         row_use = '0;
         col_use = '0;
      end else begin
         row_use = row_ff;
         col_use = col_ff;
      end
      col_wrap = (col_use == last_ff);
      row_wrap = (row_use == last_ff);

      // write current bank at (r, c), read previous bank at (n-1-c, r)
      wr_addr = {bank_ff, row_use, col_use};
      rd_addr = {~bank_ff, last_ff - col_use, row_use};
      rd_en   = accept && prev_ready_ff;

      row_in        = row_ff;
      col_in        = col_ff;
      last_in       = last_ff;
      bank_in       = bank_ff;
      prev_ready_in = prev_ready_ff;
      s1_valid_in   = rd_en;

      if (csr_write) begin
         last_in       = side_to_last(csr_frame_side);
         row_in        = '0;
         col_in        = '0;
         prev_ready_in = 1'b0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               // frame complete: swap banks
               row_in        = '0;
               bank_in       = ~bank_ff;
               prev_ready_in = 1'b1;
            end else begin
               row_in = row_use + SIDE_BITS'(1);
            end
         end else begin
            row_in = row_use;
            col_in = col_use + SIDE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         last_ff       <= pos_type'(MAX_SIDE - 1);
         bank_ff       <= 1'b0;
         prev_ready_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         last_ff       <= last_in;
         bank_ff       <= bank_in;
         prev_ready_ff <= prev_ready_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   // frame end flag travels alongside the memory read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_end_ff <= col_wrap && row_wrap;
      end
   end

   rot90_frame_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (pixel_type'(req_pixel_in)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign push_item.pixel     = rd_data;
   assign push_item.frame_end = s1_end_ff;

   // result queue decouples rsp_stall from the input side
   rot90_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .count     (fifo_count)
   );

   assign rsp_valid     = (fifo_count != '0);
   assign pop           = rsp_valid && !rsp_stall;
   assign rsp_pixel_out = signed'(head_item.pixel);
   assign rsp_frame_end = head_item.frame_end;

endmodule

@@ src/rot90_frame_store.sv @@
module rot90_frame_store (
   input  logic                clock,
   input  logic                wr_en,
   input  rot90_pkg::addr_type wr_addr,
   input  rot90_pkg::pixel_type wr_data,
   input  logic                rd_en,
   input  rot90_pkg::addr_type rd_addr,
   output rot90_pkg::pixel_type rd_data
);
   import rot90_pkg::*;

   pixel_type mem [STORE_WORDS];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rot90_rsp_fifo.sv @@
module rot90_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  rot90_pkg::rsp_item_type             push_item,
   input  logic                                pop,
   output rot90_pkg::rsp_item_type             head_item,
   output logic [rot90_pkg::FIFO_CNT_BITS-1:0] count
);
   import rot90_pkg::*;

   rsp_item_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (!push && pop) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ src/rot90_checker.sv @@
module rot90_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [rot90_pkg::PIXEL_BITS-1:0] rsp_pixel_out,
   input logic                              rsp_frame_end
);

   // nothing pending and input open right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("results or stall present after reset");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pixel_out)
                                    && $stable(rsp_frame_end)))
      else $error("stalled result changed");

   // an empty result side never backs up the input next cycle
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall)
      else $error("input stalled with no result waiting");

   // input stall only starts from back pressure on the result side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall without result back pressure");

endmodule

bind matrix_rotate_90_clockwise_unit rot90_checker u_rot90_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import rot90_pkg::*;

   // results pass the memory read register and then the result queue; the settle wait covers any in-flight write
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   // cycles with no item moving on any channel before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 24;
   localparam int DIRECTED_ROWS  = 25;
   // phases at the largest side: a partial frame that the next write drops
   localparam int BIG_PHASE      = 3;
   localparam int HUGE_PHASE     = 12;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // one line of the directed table: either a side write or one item,
   // with the expected result typed in when check_typed is set
   typedef struct packed {
      row_kind_type          kind;
      logic [CFG_BITS-1:0]   side;
      pixel_type             pixel;
      logic                  check_typed;
      logic                  exp_some;
      pixel_type             exp_pixel;
      logic                  exp_end;
   } stim_row_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic signed [PIXEL_BITS-1:0]  req_pixel_in   = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic signed [PIXEL_BITS-1:0]  rsp_pixel_out;
   logic                          rsp_frame_end;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [CFG_BITS-1:0]           csr_frame_side = '0;

   // shadow of the block: both frame banks, write position, bank select
   pixel_type                     frame_store [2][MAX_SIDE*MAX_SIDE];
   logic [CFG_BITS-1:0]           side_reg        = CFG_BITS'(MAX_SIDE);
   int                            wr_row          = 0;
   int                            wr_col          = 0;
   logic                          wr_bank         = 1'b0;
   logic                          prev_frame_full = 1'b0;

   // rotated elements predicted but not yet seen on the result channel
   rsp_item_type                  rotated_pending [$];

   int                            mismatches      = 0;
   int                            quiet_cycles    = 0;
   int                            send_idle_pct   = 28;
   int                            recv_idle_pct   = 46;

   stim_row_type                  directed_rows [DIRECTED_ROWS];

   matrix_rotate_90_clockwise_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_frame_side (csr_frame_side)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // side actually used: zero acts as one, anything past the bank size clamps
   function automatic int side_in_use();
      int n;
      n = int'(side_reg);
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_SIDE) begin
         n = MAX_SIDE;
      end
      return n;
   endfunction

   // store one element in the bank being filled and fetch the element of the
   // previous frame that lands on the same spot once rotated clockwise;
   // returns 1 when a completed frame exists so an element comes out
   function automatic logic rotate_step(input pixel_type px, output pixel_type out_px,
                                        output logic out_end);
      int   n;
      int   r;
      int   c;
      logic emitted;
      n = side_in_use();
      r = wr_row;
      c = wr_col;
      if (r >= n || c >= n) begin
         r = 0;
         c = 0;
      end
      frame_store[wr_bank][r*MAX_SIDE + c] = px;
      emitted = prev_frame_full;
      // row r, column c of the rotated frame is previous[n-1-c][r]
      out_px  = frame_store[~wr_bank][(n-1-c)*MAX_SIDE + r];
      out_end = (r == n-1) && (c == n-1);
      c++;
      if (c >= n) begin
         c = 0;
         r++;
         if (r >= n) begin
            // frame complete: swap banks, the finished one is read next frame
            r = 0;
            wr_bank = ~wr_bank;
            prev_frame_full = 1'b1;
         end
      end
      wr_row = r;
      wr_col = c;
      return emitted;
   endfunction

   // half the time full-range random, otherwise one of four corner values
   function automatic pixel_type rand_pixel();
      pixel_type px;
      case ($urandom_range(7))
         0: px = 32'h8000_0000;
         1: px = 32'h7FFF_FFFF;
         2: px = 32'hFFFF_FFFF;
         3: px = 32'h0000_0000;
         default: px = $urandom;
      endcase
      return px;
   endfunction

   // offer one item, idling at random first; the expectation is recorded at
   // the edge where the item is taken
   task automatic send_item(input pixel_type px, input logic check_typed,
                            input logic exp_some, input pixel_type exp_pixel,
                            input logic exp_end);
      pixel_type    model_pixel;
      logic         model_end;
      logic         model_some;
      rsp_item_type due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      do @(posedge clock); while (req_stall);
      model_some = rotate_step(px, model_pixel, model_end);
      if (check_typed) begin
         if (exp_some) begin
            due.pixel     = exp_pixel;
            due.frame_end = exp_end;
            rotated_pending.insert(rotated_pending.size(), due);
         end
      end else if (model_some) begin
         due.pixel     = model_pixel;
         due.frame_end = model_end;
         rotated_pending.insert(rotated_pending.size(), due);
      end
   endtask

   // stop offering items, let every expected element drain and give any
   // element that produces nothing time to land in the bank
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rotated_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // side write restarts the stream: position back to the frame origin and the
   // completed frame is dropped, bank select is kept
   task automatic write_side(input logic [CFG_BITS-1:0] side);
      csr_valid      <= 1'b1;
      csr_frame_side <= side;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      side_reg        = side;
      wr_row          = 0;
      wr_col          = 0;
      prev_frame_full = 1'b0;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result checker, in order against the oldest expectation
   always @(posedge clock) begin
      rsp_item_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotated_pending.size() == 0) begin
            $error("rotated element with none expected: pixel_out %0d frame_end %0b",
                   rsp_pixel_out, rsp_frame_end);
            mismatches++;
         end else begin
            due = rotated_pending.pop_front();
            if (rsp_pixel_out !== due.pixel) begin
               $error("pixel_out: expected %0d, got %0d", $signed(due.pixel), rsp_pixel_out);
               mismatches++;
            end
            if (rsp_frame_end !== due.frame_end) begin
               $error("frame_end: expected %0b, got %0b", due.frame_end, rsp_frame_end);
               mismatches++;
            end
         end
      end
   end

   // hang detector: counts cycles in which no item moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int                  n;
      int                  frames;
      int                  extra;
      logic [CFG_BITS-1:0] side;

      // kind, side, pixel, typed check, result expected, expected pixel, frame end
      directed_rows = '{
         // reset side is the full 64, so a couple of items give nothing yet
         '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         // side one: each item after the first brings out the one before it, always frame end
         '{ROW_CSR,  7'd1,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
         '{ROW_ITEM, 7'd0,   32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
         '{ROW_ITEM, 7'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
         '{ROW_ITEM, 7'd0,   32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
         // side zero behaves as one; the held frame is dropped by the write
         '{ROW_CSR,  7'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h5555_5555, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'hAAAA_AAAA, 1'b1, 1'b1, 32'h5555_5555, 1'b1},
         '{ROW_ITEM, 7'd0,   32'h1234_5678, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b1},
         // two by two: first frame silent, second brings the rotated first
         '{ROW_CSR,  7'd2,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h0000_0011, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h0000_0022, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h0000_0033, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h0000_0044, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         // side past the bank clamps to 64; a partial frame that gets dropped
         '{ROW_CSR,  7'd127, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'h0F0F_0F0F, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
         '{ROW_ITEM, 7'd0,   32'hF0F0_F0F0, 1'b1, 1'b0, 32'h0000_0000, 1'b0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_side(directed_rows[i].side);
         end else begin
            send_item(directed_rows[i].pixel, directed_rows[i].check_typed,
                      directed_rows[i].exp_some, directed_rows[i].exp_pixel,
                      directed_rows[i].exp_end);
         end
      end

      // random part: per phase a new side, two to four whole frames of random content
      // and sometimes a trailing partial frame the next write drops (only that at the largest side)
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase * 3 / RANDOM_PHASES)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == BIG_PHASE) begin
            side = CFG_BITS'(MAX_SIDE);
         end else if (phase == HUGE_PHASE) begin
            side = '1;
         end else begin
            side = CFG_BITS'($urandom_range(5));
         end
         wait_idle();
         write_side(side);
         n = side_in_use();
         // a full frame at the largest side is too long, so only its first rows
         if (n == MAX_SIDE) begin
            frames = 0;
            extra  = $urandom_range(2*MAX_SIDE, MAX_SIDE);
         end else begin
            frames = $urandom_range(4, 2);
            extra  = ($urandom_range(1) == 0) ? 0 : $urandom_range(n*n - 1);
         end
         repeat (frames * n * n + extra) begin
            send_item(rand_pixel(), 1'b0, 1'b0, '0, 1'b0);
         end
      end

      req_valid <= 1'b0;
      while (rotated_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
